// ===== hw/rtl/riot_pkg.sv =====
// ---------------------------------------------------------------------------
// RIOT package
// Shared types and constants for the two-port I/O and interval timer.
// ---------------------------------------------------------------------------
`default_nettype none

package riot_pkg;

   localparam int unsigned DATA_W  = 8;
   localparam int unsigned OFFS_W  = 4;
   localparam int unsigned TICKS_W = 19;

   // Bit positions inside the register offset.
   localparam int unsigned OFFS_TIMER_BIT  = 2;
   localparam int unsigned OFFS_IRQ_EN_BIT = 3;
   localparam int unsigned OFFS_STATUS_BIT = 0;

   localparam logic [DATA_W-1:0] RDATA_IDLE  = 8'hff;
   localparam logic [DATA_W-1:0] STATUS_FLAG = 8'h80;
   localparam logic [DATA_W-1:0] SHOT_START  = 8'hff;

   typedef enum logic [1:0] {
      FUNC_READ  = 2'd0,
      FUNC_WRITE = 2'd1,
      FUNC_TICK  = 2'd2,
      FUNC_IDLE  = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      REG_PA_DATA = 2'd0,
      REG_PA_DIR  = 2'd1,
      REG_PB_DATA = 2'd2,
      REG_PB_DIR  = 2'd3
   } port_reg_type;

   typedef enum logic [1:0] {
      PRE_1    = 2'd0,
      PRE_8    = 2'd1,
      PRE_64   = 2'd2,
      PRE_1024 = 2'd3
   } prescale_type;

   // One request as it is executed against the register state.
   typedef struct packed {
      logic              fire;
      func_type          func;
      logic [OFFS_W-1:0] offset;
      logic [DATA_W-1:0] wdata;
   } op_type;

endpackage

`default_nettype wire

// ===== hw/rtl/riot_ports.sv =====
// ---------------------------------------------------------------------------
// RIOT ports
// Output latches and direction registers of ports A and B, with read merge.
// ---------------------------------------------------------------------------
`default_nettype none

module riot_ports
   import riot_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire op_type            op,
   input  wire logic [DATA_W-1:0] pa_pins,
   input  wire logic [DATA_W-1:0] pb_pins,
   output      logic [DATA_W-1:0] port_rdata,
   output      logic [DATA_W-1:0] pa_latch_in,
   output      logic [DATA_W-1:0] pb_latch_in
);

   logic [DATA_W-1:0] pa_latch_ff;
   logic [DATA_W-1:0] pa_dir_ff;
   logic [DATA_W-1:0] pb_latch_ff;
   logic [DATA_W-1:0] pb_dir_ff;
   logic [DATA_W-1:0] pa_dir_in;
   logic [DATA_W-1:0] pb_dir_in;
   port_reg_type      sel;
   logic              wr;

   assign sel = port_reg_type'(op.offset[1:0]);
   assign wr  = op.fire && (op.func == FUNC_WRITE) && !op.offset[OFFS_TIMER_BIT];

   // Pins where the direction bit is clear, the latch where it is set.
   always_comb begin
      unique case (sel)
         REG_PA_DATA: port_rdata = (pa_pins & ~pa_dir_ff) | (pa_latch_ff & pa_dir_ff);
         REG_PA_DIR:  port_rdata = pa_dir_ff;
         REG_PB_DATA: port_rdata = (pb_pins & ~pb_dir_ff) | (pb_latch_ff & pb_dir_ff);
         REG_PB_DIR:  port_rdata = pb_dir_ff;
         default:     port_rdata = pb_dir_ff;
      endcase
   end

   always_comb begin
      pa_latch_in = pa_latch_ff;
      pa_dir_in   = pa_dir_ff;
      pb_latch_in = pb_latch_ff;
      pb_dir_in   = pb_dir_ff;
      if (wr) begin
         unique case (sel)
            REG_PA_DATA: pa_latch_in = op.wdata;
            REG_PA_DIR:  pa_dir_in   = op.wdata;
            REG_PB_DATA: pb_latch_in = op.wdata;
            REG_PB_DIR:  pb_dir_in   = op.wdata;
            default:     pb_dir_in   = op.wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pa_latch_ff <= '0;
         pa_dir_ff   <= '0;
         pb_latch_ff <= '0;
         pb_dir_ff   <= '0;
      end else begin
         pa_latch_ff <= pa_latch_in;
         pa_dir_ff   <= pa_dir_in;
         pb_latch_ff <= pb_latch_in;
         pb_dir_ff   <= pb_dir_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/riot_timer.sv =====
// ---------------------------------------------------------------------------
// RIOT interval timer
// Prescaled down counter, expiry flag, post-expiry count and interrupt enable.
// ---------------------------------------------------------------------------
`default_nettype none

module riot_timer
   import riot_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire op_type            op,
   output      logic [DATA_W-1:0] timer_rdata,
   output      logic              irq_level_in
);

   prescale_type       prescale_ff, prescale_in, wr_prescale;
   logic               shot_ff, shot_in;
   logic [TICKS_W-1:0] ticks_ff, ticks_in, ticks_dec, load_ext;
   logic [DATA_W-1:0]  since_ff, since_in;
   logic               flag_ff, flag_in;
   logic               irq_en_ff, irq_en_in;
   logic [DATA_W-1:0]  count_value;
   logic [DATA_W:0]    load_base;
   logic               timer_acc;
   logic               is_status;

   assign wr_prescale = prescale_type'(op.offset[1:0]);
   assign timer_acc   = op.fire && op.offset[OFFS_TIMER_BIT] &&
                        (op.func == FUNC_READ || op.func == FUNC_WRITE);
   assign is_status   = op.offset[OFFS_STATUS_BIT];
   assign ticks_dec   = ticks_ff - TICKS_W'(1);
   assign load_base   = {1'b0, op.wdata} + (DATA_W+1)'(1);
   assign load_ext    = TICKS_W'(load_base);

   always_comb begin
      if (shot_ff) begin
         count_value = SHOT_START - since_ff;
      end else begin
         unique case (prescale_ff)
            PRE_1:    count_value = ticks_ff[7:0];
            PRE_8:    count_value = ticks_ff[10:3];
            PRE_64:   count_value = ticks_ff[13:6];
            PRE_1024: count_value = ticks_ff[17:10];
            default:  count_value = ticks_ff[7:0];
         endcase
      end
      timer_rdata = is_status ? (flag_ff ? STATUS_FLAG : '0) : count_value;
   end

   always_comb begin
      prescale_in = prescale_ff;
      shot_in     = shot_ff;
      ticks_in    = ticks_ff;
      since_in    = since_ff;
      flag_in     = flag_ff;
      irq_en_in   = irq_en_ff;
      if (timer_acc) begin
         irq_en_in = op.offset[OFFS_IRQ_EN_BIT];
      end
      if (op.fire) begin
         unique case (op.func)
            FUNC_READ: begin
               if (op.offset[OFFS_TIMER_BIT] && !is_status) begin
                  flag_in = 1'b0;
               end
            end
            FUNC_WRITE: begin
               if (op.offset[OFFS_TIMER_BIT]) begin
                  flag_in     = 1'b0;
                  shot_in     = 1'b0;
                  prescale_in = wr_prescale;
                  since_in    = '0;
                  unique case (wr_prescale)
                     PRE_1:    ticks_in = load_ext;
                     PRE_8:    ticks_in = load_ext << 3;
                     PRE_64:   ticks_in = load_ext << 6;
                     PRE_1024: ticks_in = load_ext << 10;
                     default:  ticks_in = load_ext;
                  endcase
               end
            end
            FUNC_TICK: begin
               if (shot_ff) begin
                  // After expiry the count runs down once per tick and holds at zero.
                  if (since_ff != SHOT_START) begin
                     since_in = since_ff + DATA_W'(1);
                  end
               end else if (ticks_ff != '0) begin
                  ticks_in = ticks_dec;
                  if (ticks_dec == '0) begin
                     flag_in  = 1'b1;
                     shot_in  = 1'b1;
                     since_in = '0;
                  end
               end
            end
            FUNC_IDLE: begin
            end
            default: begin
            end
         endcase
      end
      irq_level_in = flag_in & irq_en_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prescale_ff <= PRE_1;
         shot_ff     <= 1'b0;
         ticks_ff    <= '0;
         since_ff    <= '0;
         flag_ff     <= 1'b0;
         irq_en_ff   <= 1'b0;
      end else begin
         prescale_ff <= prescale_in;
         shot_ff     <= shot_in;
         ticks_ff    <= ticks_in;
         since_ff    <= since_in;
         flag_ff     <= flag_in;
         irq_en_ff   <= irq_en_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/riot_ports_and_interval_timer.sv =====
// ---------------------------------------------------------------------------
// RIOT ports and interval timer
// Two 8-bit I/O ports with direction registers and a prescaled interval timer.
// ---------------------------------------------------------------------------
// Each request is a bus read, a bus write, one base-clock tick or an idle
// request, and each request yields exactly one response carrying the read
// data (0xff for anything but a read), the interrupt line and both port
// output latches as they stand after the request. A request is captured
// in an input register, executed against the port and timer state, and
// its response is held in an output register; while the response channel
// is ready a new request can be taken every cycle, so the sustained rate
// is one request per clock. The response is presented from the output
// register once the request has passed through the input register.
// The state update happens when a request leaves the input register, so
// a stalled response channel holds the pipeline and requests are executed
// strictly in order.
// A timer write loads (data + 1) times a prescale of 1, 8, 64 or 1024 ticks;
// on expiry the flag is set and the count runs down from 255, once per tick,
// stopping at zero. Reading the count clears the flag; any timer-part access
// sets the interrupt enable from offset bit 3.
// ---------------------------------------------------------------------------
`default_nettype none

module riot_ports_and_interval_timer
   import riot_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_ready,
   input  wire logic [1:0]        req_func,
   input  wire logic [OFFS_W-1:0] req_offset,
   input  wire logic [DATA_W-1:0] req_wdata,
   input  wire logic [DATA_W-1:0] req_pa_pins,
   input  wire logic [DATA_W-1:0] req_pb_pins,
   output      logic              rsp_valid,
   input  wire logic              rsp_ready,
   output      logic [DATA_W-1:0] rsp_rdata,
   output      logic              rsp_irq_line,
   output      logic [DATA_W-1:0] rsp_pa_drive,
   output      logic [DATA_W-1:0] rsp_pb_drive
);

   // Input register.
   logic              in_valid_ff;
   func_type          in_func_ff;
   logic [OFFS_W-1:0] in_offset_ff;
   logic [DATA_W-1:0] in_wdata_ff;
   logic [DATA_W-1:0] in_pa_pins_ff;
   logic [DATA_W-1:0] in_pb_pins_ff;

   // Response register.
   logic              out_valid_ff;
   logic [DATA_W-1:0] out_rdata_ff;
   logic              out_irq_ff;
   logic [DATA_W-1:0] out_pa_ff;
   logic [DATA_W-1:0] out_pb_ff;

   logic              out_free;
   logic              advance;
   logic              accept;
   op_type            op;
   logic [DATA_W-1:0] port_rdata;
   logic [DATA_W-1:0] timer_rdata;
   logic [DATA_W-1:0] rdata_in;
   logic [DATA_W-1:0] pa_latch_in;
   logic [DATA_W-1:0] pb_latch_in;
   logic              irq_level_in;

   // The response register frees up when it is empty or being drained; the
   // request in the input register executes exactly when it can move there.
   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;
   assign accept    = req_valid && req_ready;

   assign op.fire   = advance;
   assign op.func   = in_func_ff;
   assign op.offset = in_offset_ff;
   assign op.wdata  = in_wdata_ff;

   riot_ports u_ports (
      .clock       (clock),
      .reset       (reset),
      .op          (op),
      .pa_pins     (in_pa_pins_ff),
      .pb_pins     (in_pb_pins_ff),
      .port_rdata  (port_rdata),
      .pa_latch_in (pa_latch_in),
      .pb_latch_in (pb_latch_in)
   );

   riot_timer u_timer (
      .clock        (clock),
      .reset        (reset),
      .op           (op),
      .timer_rdata  (timer_rdata),
      .irq_level_in (irq_level_in)
   );

   // Reads pick the port or timer part by offset bit 2; all else reads 0xff.
   always_comb begin
      if (in_func_ff == FUNC_READ) begin
         rdata_in = in_offset_ff[OFFS_TIMER_BIT] ? timer_rdata : port_rdata;
      end else begin
         rdata_in = RDATA_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (out_free) begin
            out_valid_ff <= in_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_func_ff    <= func_type'(req_func);
         in_offset_ff  <= req_offset;
         in_wdata_ff   <= req_wdata;
         in_pa_pins_ff <= req_pa_pins;
         in_pb_pins_ff <= req_pb_pins;
      end
      if (advance) begin
         out_rdata_ff <= rdata_in;
         out_irq_ff   <= irq_level_in;
         out_pa_ff    <= pa_latch_in;
         out_pb_ff    <= pb_latch_in;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_rdata    = out_rdata_ff;
   assign rsp_irq_line = out_irq_ff;
   assign rsp_pa_drive = out_pa_ff;
   assign rsp_pb_drive = out_pb_ff;

endmodule

`default_nettype wire

// ===== sim/riot_ports_and_interval_timer_tb.sv =====
// ---------------------------------------------------------------------------
// RIOT ports and interval timer testbench
// Drives bus reads, bus writes, base-clock ticks and idle requests. Each
// accepted request runs through a cycle-free model of the ports and the
// timer, and every response is checked field by field against that model.
// ---------------------------------------------------------------------------
`default_nettype none

module riot_ports_and_interval_timer_tb;

   import riot_pkg::*;

   localparam int CLK_PERIOD = 10;
   // Longest stretch of cycles with no request and no response accepted.
   // This leaves ample room for the deliberate response hold-off.
   localparam int IDLE_LIMIT = 2000;
   localparam int RANDOM_ITEMS = 100;
   localparam int MAX_REPORTS = 10;

   // Timer mode after expiry: the count runs down from 255 once per tick.
   localparam logic [2:0] MODE_EXPIRED = 3'd4;

   // Timer-part read selects (offset bit 0).
   localparam logic [1:0] SEL_COUNT  = 2'b00;
   localparam logic [1:0] SEL_STATUS = 2'b01;

   typedef struct packed {
      logic [DATA_W-1:0] rdata;
      logic              irq;
      logic [DATA_W-1:0] pa;
      logic [DATA_W-1:0] pb;
   } rsp_fields_type;

   // Clock and reset. Inputs are driven at the falling edge and outputs are
   // sampled at the rising edge, so nothing depends on event order.
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              req_valid   = 1'b0;
   logic              req_ready;
   logic [1:0]        req_func    = FUNC_IDLE;
   logic [OFFS_W-1:0] req_offset  = '0;
   logic [DATA_W-1:0] req_wdata   = '0;
   logic [DATA_W-1:0] req_pa_pins = '0;
   logic [DATA_W-1:0] req_pb_pins = '0;
   logic              rsp_valid;
   logic              rsp_ready   = 1'b0;
   logic [DATA_W-1:0] rsp_rdata;
   logic              rsp_irq_line;
   logic [DATA_W-1:0] rsp_pa_drive;
   logic [DATA_W-1:0] rsp_pb_drive;

   always #(CLK_PERIOD / 2) clock = ~clock;

   riot_ports_and_interval_timer i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_func     (req_func),
      .req_offset   (req_offset),
      .req_wdata    (req_wdata),
      .req_pa_pins  (req_pa_pins),
      .req_pb_pins  (req_pb_pins),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_rdata    (rsp_rdata),
      .rsp_irq_line (rsp_irq_line),
      .rsp_pa_drive (rsp_pa_drive),
      .rsp_pb_drive (rsp_pb_drive)
   );

   // -----------------------------------------------------------------------
   // Shadow copy of the port and timer state. It is advanced once for every
   // request the block accepts, in acceptance order, and each step yields
   // the response that request must produce.
   // -----------------------------------------------------------------------
   logic [DATA_W-1:0]  pa_out_q, pa_dir_q, pb_out_q, pb_dir_q;
   logic [2:0]         tmr_mode_q;
   logic [TICKS_W-1:0] tmr_count_q;
   logic [DATA_W-1:0]  tmr_after_q;
   logic               tmr_flag_q, tmr_irq_en_q, irq_q;

   rsp_fields_type due_responses[$];
   int             mismatch_count = 0;
   int             items_sent = 0;
   int             burst_left = 0;
   int             rsp_hold_cycles = 0;

   function automatic int prescale_shift(prescale_type p);
      case (p)
         PRE_1:   return 0;
         PRE_8:   return 3;
         PRE_64:  return 6;
         default: return 10;
      endcase
   endfunction

   function automatic void clear_shadow_state();
      pa_out_q     = '0;
      pa_dir_q     = '0;
      pb_out_q     = '0;
      pb_dir_q     = '0;
      tmr_mode_q   = 3'(PRE_1);
      tmr_count_q  = '0;
      tmr_after_q  = '0;
      tmr_flag_q   = 1'b0;
      tmr_irq_en_q = 1'b0;
      irq_q        = 1'b0;
   endfunction

   // The value a count read returns: after expiry it is the down-count from
   // 255, before that the remaining ticks scaled back by the prescale.
   function automatic logic [DATA_W-1:0] timer_reading();
      logic [TICKS_W-1:0] scaled;
      if (tmr_mode_q >= MODE_EXPIRED) return SHOT_START - tmr_after_q;
      scaled = tmr_count_q >> prescale_shift(prescale_type'(tmr_mode_q[1:0]));
      return scaled[DATA_W-1:0];
   endfunction

   function automatic rsp_fields_type predict_response(
      func_type f, logic [OFFS_W-1:0] off, logic [DATA_W-1:0] wd,
      logic [DATA_W-1:0] pa_pins, logic [DATA_W-1:0] pb_pins);
      rsp_fields_type r;
      r.rdata = RDATA_IDLE;
      case (f)
         FUNC_READ: begin
            if (!off[OFFS_TIMER_BIT]) begin
               case (port_reg_type'(off[1:0]))
                  REG_PA_DATA: r.rdata = (pa_pins & ~pa_dir_q) | (pa_out_q & pa_dir_q);
                  REG_PA_DIR:  r.rdata = pa_dir_q;
                  REG_PB_DATA: r.rdata = (pb_pins & ~pb_dir_q) | (pb_out_q & pb_dir_q);
                  default:     r.rdata = pb_dir_q;
               endcase
            end else begin
               if (!off[OFFS_STATUS_BIT]) begin
                  r.rdata    = timer_reading();
                  tmr_flag_q = 1'b0;
               end else begin
                  r.rdata = tmr_flag_q ? STATUS_FLAG : 8'h00;
               end
               tmr_irq_en_q = off[OFFS_IRQ_EN_BIT];
            end
         end
         FUNC_WRITE: begin
            if (!off[OFFS_TIMER_BIT]) begin
               case (port_reg_type'(off[1:0]))
                  REG_PA_DATA: pa_out_q = wd;
                  REG_PA_DIR:  pa_dir_q = wd;
                  REG_PB_DATA: pb_out_q = wd;
                  default:     pb_dir_q = wd;
               endcase
            end else begin
               tmr_irq_en_q = off[OFFS_IRQ_EN_BIT];
               tmr_flag_q   = 1'b0;
               tmr_mode_q   = {1'b0, off[1:0]};
               tmr_count_q  = (TICKS_W'(wd) + 1'b1)
                              << prescale_shift(prescale_type'(off[1:0]));
               tmr_after_q  = '0;
            end
         end
         FUNC_TICK: begin
            if (tmr_mode_q >= MODE_EXPIRED) begin
               if (tmr_after_q != SHOT_START) tmr_after_q = tmr_after_q + 1'b1;
            end else if (tmr_count_q != '0) begin
               tmr_count_q = tmr_count_q - 1'b1;
               if (tmr_count_q == '0) begin
                  tmr_flag_q  = 1'b1;
                  tmr_mode_q  = MODE_EXPIRED;
                  tmr_after_q = '0;
               end
            end
         end
         default: ;
      endcase
      irq_q   = tmr_flag_q & tmr_irq_en_q;
      r.irq   = irq_q;
      r.pa    = pa_out_q;
      r.pb    = pb_out_q;
      return r;
   endfunction

   // -----------------------------------------------------------------------
   // Request side. Every task here starts and ends at a falling edge. The
   // sender works in bursts; between bursts valid may drop for a random gap.
   // Valid is lowered only when a gap starts or when waiting for responses,
   // never between two requests of one burst.
   // -----------------------------------------------------------------------
   task automatic send_request(func_type f, logic [OFFS_W-1:0] off,
                               logic [DATA_W-1:0] wd, logic [DATA_W-1:0] pa,
                               logic [DATA_W-1:0] pb);
      int gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         burst_left = $urandom_range(1, 20);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_func    <= f;
      req_offset  <= off;
      req_wdata   <= wd;
      req_pa_pins <= pa;
      req_pb_pins <= pb;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      due_responses.push_back(predict_response(f, off, wd, pa, pb));
      if (f != FUNC_IDLE) items_sent++;
      @(negedge clock);
   endtask

   // Stop offering requests until every response has been seen.
   task automatic wait_for_responses();
      req_valid <= 1'b0;
      burst_left = 0;
      while (due_responses.size() != 0) @(negedge clock);
   endtask

   function automatic logic [OFFS_W-1:0] port_off(port_reg_type r, logic bit3 = 1'b0);
      return {bit3, 1'b0, r};
   endfunction

   function automatic logic [OFFS_W-1:0] timer_off(logic irq_en, logic [1:0] sel);
      return {irq_en, 1'b1, sel};
   endfunction

   task automatic bus_write(logic [OFFS_W-1:0] off, logic [DATA_W-1:0] wd);
      send_request(FUNC_WRITE, off, wd, DATA_W'($urandom), DATA_W'($urandom));
   endtask

   task automatic bus_read(logic [OFFS_W-1:0] off,
                           logic [DATA_W-1:0] pa = DATA_W'($urandom),
                           logic [DATA_W-1:0] pb = DATA_W'($urandom));
      send_request(FUNC_READ, off, DATA_W'($urandom), pa, pb);
   endtask

   // The data, offset and pin fields of a tick are don't-cares, so they get
   // random values to show that the block ignores them.
   task automatic tick(int n);
      repeat (n) send_request(FUNC_TICK, OFFS_W'($urandom), DATA_W'($urandom),
                              DATA_W'($urandom), DATA_W'($urandom));
   endtask

   task automatic send_noise_item();
      send_request(func_type'($urandom_range(0, 3)), OFFS_W'($urandom),
                   DATA_W'($urandom), DATA_W'($urandom), DATA_W'($urandom));
   endtask

   // -----------------------------------------------------------------------
   // Tests.
   // -----------------------------------------------------------------------

   // Port data merges pins and latch under the direction mask; offset bit 3
   // has no effect on the port part.
   task automatic test_port_registers();
      bus_read(port_off(REG_PA_DATA), 8'hff, 8'h00);
      bus_write(port_off(REG_PA_DATA), 8'hff);
      bus_write(port_off(REG_PA_DIR), 8'hf0);
      bus_read(port_off(REG_PA_DATA), 8'h00, 8'hff);
      bus_write(port_off(REG_PB_DATA, 1'b1), 8'h00);
      bus_write(port_off(REG_PB_DIR, 1'b1), 8'hff);
      bus_read(port_off(REG_PB_DATA), 8'hff, 8'hff);
      bus_write(port_off(REG_PB_DIR), 8'ha5);
      bus_read(port_off(REG_PB_DATA, 1'b1), 8'h5a, 8'hff);
      bus_read(port_off(REG_PA_DIR));
      bus_read(port_off(REG_PB_DIR, 1'b1));
   endtask

   // Stopped timer, a short count to expiry with the interrupt enabled,
   // status and count reads, the down-count after expiry, and each prescale.
   task automatic test_timer_basics();
      bus_read(timer_off(1'b0, SEL_STATUS));
      bus_read(timer_off(1'b0, SEL_COUNT));
      tick(1);
      send_request(FUNC_IDLE, OFFS_W'($urandom), DATA_W'($urandom),
                   DATA_W'($urandom), DATA_W'($urandom));
      bus_write(timer_off(1'b1, PRE_1), 8'd2);
      bus_read(timer_off(1'b1, SEL_COUNT));
      tick(3);
      bus_read(timer_off(1'b1, SEL_STATUS));
      tick(1);
      bus_read(timer_off(1'b1, SEL_COUNT));
      // The 2048-tick load wraps to zero in the low eight bits.
      bus_write(timer_off(1'b0, PRE_8), 8'hff);
      bus_read(timer_off(1'b0, SEL_COUNT));
      tick(8);
      bus_read(timer_off(1'b0, SEL_COUNT));
      bus_write(timer_off(1'b1, PRE_64), 8'h80);
      bus_read(timer_off(1'b1, SEL_COUNT));
      bus_write(timer_off(1'b0, PRE_1024), 8'd1);
      bus_read(timer_off(1'b0, SEL_COUNT));
   endtask

   // After expiry the count runs down once per tick and sticks at zero.
   task automatic test_expiry_floor();
      bus_write(timer_off(1'b1, PRE_1), 8'd0);
      tick(1);
      bus_read(timer_off(1'b1, SEL_STATUS));
      tick(260);
      bus_read(timer_off(1'b1, SEL_COUNT));
      bus_read(timer_off(1'b0, SEL_STATUS));
   endtask

   // The largest prescale: a full load wraps to zero in the scaled count and
   // reads 255 one tick later; a minimum load reads one, then zero.
   task automatic test_long_prescale();
      bus_write(timer_off(1'b1, PRE_1024), 8'hff);
      bus_read(timer_off(1'b1, SEL_COUNT));
      tick(1);
      bus_read(timer_off(1'b1, SEL_COUNT));
      bus_write(timer_off(1'b0, PRE_1024), 8'd0);
      bus_read(timer_off(1'b0, SEL_COUNT));
      tick(1);
      bus_read(timer_off(1'b0, SEL_COUNT));
      bus_read(timer_off(1'b1, SEL_STATUS));
   endtask

   // The receiver holds off for a long stretch while requests keep coming,
   // so the block fills up and stalls its input. Then the sender pauses
   // until all responses are back.
   task automatic test_backpressure();
      rsp_hold_cycles = 80;
      burst_left      = 40;
      repeat (24) begin
         if ($urandom_range(0, 1) == 0) tick(1);
         else send_noise_item();
      end
      wait_for_responses();
   endtask

   // Mostly well-formed timer sequences: a load, then roughly enough ticks
   // to reach expiry, with port traffic and reads mixed in. The rest is
   // unconstrained noise.
   task automatic test_random_traffic();
      int           target, span, run;
      prescale_type pre;
      logic [7:0]   load;
      target = items_sent + RANDOM_ITEMS;
      while (items_sent < target) begin
         if ($urandom_range(0, 9) < 7) begin
            pre = prescale_type'($urandom_range(0, 3));
            case (pre)
               PRE_1:   load = ($urandom_range(0, 7) == 0) ? 8'($urandom)
                                                           : 8'($urandom_range(0, 24));
               PRE_8:   load = 8'($urandom_range(0, 6));
               PRE_64:  load = 8'($urandom_range(0, 1));
               default: load = 8'($urandom);
            endcase
            bus_write(timer_off(1'($urandom_range(0, 1)), pre), load);
            span = (pre == PRE_1024) ? $urandom_range(5, 40)
                                     : (int'(load) + 1) << prescale_shift(pre);
            run  = $urandom_range((span > 4) ? span - 4 : 0, span + 12);
            repeat (run) begin
               case ($urandom_range(0, 9))
                  0:       bus_read(OFFS_W'($urandom));
                  1:       bus_write({1'($urandom), 1'b0, 2'($urandom)}, DATA_W'($urandom));
                  default: tick(1);
               endcase
            end
         end else begin
            send_noise_item();
         end
      end
   endtask

   // -----------------------------------------------------------------------
   // Response side. The receiver stalls in stretches of varying density,
   // including stretches with no stall at all, and obeys a requested hold.
   // -----------------------------------------------------------------------
   initial begin : rsp_ready_pattern
      int mode_left;
      int mode;
      mode_left = 0;
      mode      = 0;
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_ready <= 1'b0;
            repeat (rsp_hold_cycles) @(negedge clock);
            rsp_hold_cycles = 0;
         end else begin
            if (mode_left == 0) begin
               mode      = $urandom_range(0, 2);
               mode_left = $urandom_range(10, 60);
            end
            mode_left--;
            case (mode)
               0:       rsp_ready <= 1'b1;
               1:       rsp_ready <= ($urandom_range(0, 3) != 0);
               default: rsp_ready <= ($urandom_range(0, 2) == 0);
            endcase
         end
      end
   end

   task automatic report_mismatch(string field, logic [DATA_W-1:0] want,
                                  logic [DATA_W-1:0] seen);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("[%0t] %s mismatch: expected %02h, got %02h", $realtime, field, want, seen);
   endtask

   // Every accepted response is compared with the oldest pending prediction.
   always @(posedge clock) begin : rsp_check
      rsp_fields_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (due_responses.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("[%0t] response with no request pending: rdata %02h",
                        $realtime, rsp_rdata);
         end else begin
            want = due_responses.pop_front();
            if (rsp_rdata !== want.rdata) report_mismatch("rdata", want.rdata, rsp_rdata);
            if (rsp_irq_line !== want.irq)
               report_mismatch("irq_line", 8'(want.irq), 8'(rsp_irq_line));
            if (rsp_pa_drive !== want.pa) report_mismatch("pa_drive", want.pa, rsp_pa_drive);
            if (rsp_pb_drive !== want.pb) report_mismatch("pb_drive", want.pb, rsp_pb_drive);
         end
      end
   end

   // Watchdog: too many cycles without any handshake means the block hung
   // or lost a response.
   int idle_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // -----------------------------------------------------------------------
   // Test sequence.
   // -----------------------------------------------------------------------
   initial begin
      clear_shadow_state();
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      test_port_registers();
      test_timer_basics();
      test_expiry_floor();
      test_backpressure();
      test_long_prescale();
      test_random_traffic();

      // Drain, then give the two-stage pipeline time to show any stray
      // response.
      wait_for_responses();
      repeat (8) @(posedge clock);

      if (mismatch_count == 0 && due_responses.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
